// File: design/apma_pkg.sv
// ----------------------------------------------------------------------------
// apma_pkg
// Shared types and codes for the autopilot mode annunciator: message ids,
// flag positions, display mode codes and the selected-mode bundle.
// ----------------------------------------------------------------------------
package apma_pkg;

   localparam int unsigned NumFlags   = 18;
   localparam int unsigned ValueWidth = 18;
   localparam int unsigned CodeWidth  = 5;
   localparam int unsigned TickWidth  = 32;
   localparam int unsigned CsrWidth   = 16;

   typedef logic [CodeWidth-1:0]  mode_code_type;
   typedef logic [NumFlags-1:0]   mode_flags_type;
   typedef logic [4:0]            msg_id_type;

   // flag positions inside the mode flag word
   localparam int unsigned FLAG_ROL    = 0;
   localparam int unsigned FLAG_HDG    = 1;
   localparam int unsigned FLAG_VOR    = 2;
   localparam int unsigned FLAG_GPS    = 3;
   localparam int unsigned FLAG_APR    = 4;
   localparam int unsigned FLAG_BC     = 5;
   localparam int unsigned FLAG_LVL    = 6;
   localparam int unsigned FLAG_GA     = 7;
   localparam int unsigned FLAG_LOC    = 8;
   localparam int unsigned FLAG_VS     = 9;
   localparam int unsigned FLAG_IAS    = 10;
   localparam int unsigned FLAG_ALT    = 11;
   localparam int unsigned FLAG_ALTS   = 12;
   localparam int unsigned FLAG_GS_ARM = 15;
   localparam int unsigned FLAG_GS_ACT = 16;
   localparam int unsigned FLAG_PIT    = 17;

   // message ids
   localparam msg_id_type MSG_FLAG_FIRST = 5'd0;
   localparam msg_id_type MSG_FLAG_LAST  = 5'd17;
   localparam msg_id_type MSG_ALT_NOW    = 5'd18;
   localparam msg_id_type MSG_NEAR_50    = 5'd19;
   localparam msg_id_type MSG_NEAR_200   = 5'd20;
   localparam msg_id_type MSG_ALT_LOCK   = 5'd21;
   localparam msg_id_type MSG_VERT_SPEED = 5'd22;
   localparam msg_id_type MSG_AIRSPEED   = 5'd23;
   localparam msg_id_type MSG_SHUTDOWN   = 5'd24;
   localparam msg_id_type MSG_POWER_SAVE = 5'd25;

   // item kinds on the request tuser bit
   localparam logic CMD_MESSAGE = 1'b0;
   localparam logic CMD_TICK    = 1'b1;

   // configuration register indexes
   localparam logic CSR_FLASH_TICKS = 1'b0;
   localparam logic CSR_BLINK_HALF  = 1'b1;

   localparam logic [CsrWidth-1:0] FLASH_TICKS_RESET = 16'd3000;
   localparam logic [CsrWidth-1:0] BLINK_HALF_RESET  = 16'd500;

   // display mode codes: flag position plus one, glidepath has its own
   localparam mode_code_type MODE_NONE   = 5'd0;
   localparam mode_code_type MODE_ROL    = 5'd1;
   localparam mode_code_type MODE_HDG    = 5'd2;
   localparam mode_code_type MODE_VOR    = 5'd3;
   localparam mode_code_type MODE_GPS    = 5'd4;
   localparam mode_code_type MODE_BC     = 5'd6;
   localparam mode_code_type MODE_LVL    = 5'd7;
   localparam mode_code_type MODE_LOC    = 5'd9;
   localparam mode_code_type MODE_VS     = 5'd10;
   localparam mode_code_type MODE_IAS    = 5'd11;
   localparam mode_code_type MODE_ALT    = 5'd12;
   localparam mode_code_type MODE_ALTS   = 5'd13;
   localparam mode_code_type MODE_GS_ARM = 5'd16;
   localparam mode_code_type MODE_GS_ACT = 5'd17;
   localparam mode_code_type MODE_PIT    = 5'd18;
   localparam mode_code_type MODE_GP     = 5'd19;

   typedef struct packed {
      mode_code_type active_lateral;
      mode_code_type armed_lateral;
      mode_code_type active_vertical;
      mode_code_type armed_vertical_one;
      mode_code_type armed_vertical_two;
   } mode_sel_type;

endpackage

// File: design/autopilot_mode_annunciator.sv
// ----------------------------------------------------------------------------
// autopilot_mode_annunciator
// Keeps the autopilot mode flags, altitudes, speeds, proximity flags, tick
// time, capture flash timers and blink phase, and reports the selected modes
// and display marks for every message or tick beat.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  req     | in  | tuser: cmd; tdata: msg_id, msg_value
//  rsp     | out | tdata: modes, flash flags, blink, setting, blank, redraw
//  csr     | in  | csr_index selects capture flash length or blink half period
//
//  one beat per cycle in each direction while rsp_tready is high; a result
//  passes through the input register, then the result register
//  reset is synchronous: mode state cleared, blink visible, registers to
//  their defaults; csr_ready is always high
//  rsp_tready low holds the result register; the input register then fills
//  and req_tready drops until the result is taken
// ----------------------------------------------------------------------------
module autopilot_mode_annunciator
   import apma_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // msg_id[4:0], msg_value[22:5], zero pad
   input  logic        req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // active_lateral[4:0], armed_lateral[9:5],
                                    // active_vertical[14:10],
                                    // armed_vertical_one[19:15],
                                    // armed_vertical_two[24:20],
                                    // alt_flashing[25], alts_flashing[26],
                                    // blink_on[27], setting_value[45:28],
                                    // blank[46], redraw[47]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   // configuration
   logic [CsrWidth-1:0] flash_dur_ff, blink_half_ff;

   // input register
   logic                  in_valid_ff, in_valid_in;
   logic                  in_cmd_ff;
   msg_id_type            in_id_ff;
   logic [ValueWidth-1:0] in_value_ff;

   // result register
   logic        out_valid_ff, out_valid_in;
   logic [47:0] out_data_ff, out_data_in;

   // block state
   mode_flags_type        flags_ff, flags_in;
   logic [ValueWidth-1:0] alt_now_ff, alt_now_in;
   logic [ValueWidth-1:0] alt_lock_ff, alt_lock_in;
   logic [ValueWidth-1:0] vspeed_ff, vspeed_in;
   logic [ValueWidth-1:0] aspeed_ff, aspeed_in;
   logic [1:0]            near_ff, near_in;
   logic [TickWidth-1:0]  tick_ff, tick_in;
   logic [1:0]            marks_ff, marks_in;
   logic [TickWidth-1:0]  start_alt_ff, start_alt_in;
   logic [TickWidth-1:0]  start_alts_ff, start_alts_in;
   logic [CsrWidth-1:0]   blink_cnt_ff, blink_cnt_in;
   logic                  blink_ff, blink_in;

   logic                  advance, fire, is_tick, val_nz;
   logic                  blank, redraw;
   logic                  cond_alt, cond_alts, exp_alt, exp_alts;
   logic [TickWidth-1:0]  tick_inc, elapsed_alt, elapsed_alts;
   logic [CsrWidth-1:0]   cnt_inc;
   logic [ValueWidth-1:0] setting;
   mode_sel_type          modes;

   assign advance    = !out_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   assign is_tick = (in_cmd_ff == CMD_TICK);
   assign val_nz  = (in_value_ff != '0);

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // tick side: flash timers and blink phase
   assign tick_inc     = tick_ff + 32'd1;
   assign elapsed_alt  = tick_inc - start_alt_ff;
   assign elapsed_alts = tick_inc - start_alts_ff;
   assign exp_alt      = elapsed_alt  > {{(TickWidth-CsrWidth){1'b0}}, flash_dur_ff};
   assign exp_alts     = elapsed_alts > {{(TickWidth-CsrWidth){1'b0}}, flash_dur_ff};
   assign cnt_inc      = blink_cnt_ff + 16'd1;

   assign cond_alts = near_ff[1] && flags_ff[FLAG_ALTS] &&
                      (flags_ff[FLAG_PIT] || flags_ff[FLAG_IAS] ||
                       flags_ff[FLAG_VS] || flags_ff[FLAG_GA]);
   assign cond_alt  = flags_ff[FLAG_ALT] && !flags_ff[FLAG_ALTS] && near_ff[0];

   always_comb begin
      flags_in      = flags_ff;
      alt_now_in    = alt_now_ff;
      alt_lock_in   = alt_lock_ff;
      vspeed_in     = vspeed_ff;
      aspeed_in     = aspeed_ff;
      near_in       = near_ff;
      tick_in       = tick_ff;
      marks_in      = marks_ff;
      start_alt_in  = start_alt_ff;
      start_alts_in = start_alts_ff;
      blink_cnt_in  = blink_cnt_ff;
      blink_in      = blink_ff;
      blank         = 1'b0;
      redraw        = 1'b0;

      if (!is_tick) begin
         unique case (in_id_ff) inside
            [MSG_FLAG_FIRST:MSG_FLAG_LAST]: begin
               for (int i = 0; i < NumFlags; i++) begin
                  if (in_id_ff == msg_id_type'(i)) begin
                     flags_in[i] = val_nz;
                  end
               end
               redraw = 1'b1;
            end
            MSG_ALT_NOW: begin
               alt_now_in = in_value_ff;
               redraw     = 1'b1;
            end
            MSG_NEAR_50: begin
               near_in[0] = val_nz;
               redraw     = 1'b1;
            end
            MSG_NEAR_200: begin
               near_in[1] = val_nz;
               redraw     = 1'b1;
            end
            MSG_ALT_LOCK: begin
               alt_lock_in = in_value_ff;
               redraw      = 1'b1;
            end
            MSG_VERT_SPEED: begin
               vspeed_in = in_value_ff;
               redraw    = 1'b1;
            end
            MSG_AIRSPEED: begin
               aspeed_in = in_value_ff;
               redraw    = 1'b1;
            end
            MSG_SHUTDOWN:   blank = 1'b1;
            MSG_POWER_SAVE: blank = (in_value_ff == 18'd1);
            default: ;
         endcase
      end else begin
         tick_in = tick_inc;
         // altitude select flash
         if (cond_alts) begin
            if (!marks_ff[1] || exp_alts) begin
               marks_in[1]   = 1'b1;
               start_alts_in = tick_inc;
               redraw        = 1'b1;
            end
         end else if (marks_ff[1] && exp_alts) begin
            marks_in[1] = 1'b0;
            redraw      = 1'b1;
         end
         // altitude capture flash
         if (cond_alt) begin
            if (!marks_ff[0] || exp_alt) begin
               marks_in[0]  = 1'b1;
               start_alt_in = tick_inc;
               redraw       = 1'b1;
            end
         end else if (marks_ff[0] && exp_alt) begin
            marks_in[0] = 1'b0;
            redraw      = 1'b1;
         end
         // blink phase, a zero period toggles on every tick
         blink_cnt_in = cnt_inc;
         if (cnt_inc >= blink_half_ff) begin
            blink_cnt_in = '0;
            blink_in     = !blink_ff;
            if (marks_in != 2'b00) begin
               redraw = 1'b1;
            end
         end
      end
   end

   apma_mode_decode u_decode (
      .flags   (flags_in),
      .near_50 (near_in[0]),
      .modes   (modes)
   );

   always_comb begin
      case (modes.active_vertical)
         MODE_ALT:  setting = alt_now_in;
         MODE_ALTS: setting = alt_lock_in;
         MODE_IAS:  setting = aspeed_in;
         MODE_VS:   setting = vspeed_in;
         default:   setting = '0;
      endcase
      out_data_in = {redraw, blank, setting, blink_in, marks_in[1], marks_in[0],
                     modes.armed_vertical_two, modes.armed_vertical_one,
                     modes.active_vertical, modes.armed_lateral,
                     modes.active_lateral};
   end

   // control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         flash_dur_ff  <= FLASH_TICKS_RESET;
         blink_half_ff <= BLINK_HALF_RESET;
         flags_ff      <= '0;
         alt_now_ff    <= '0;
         alt_lock_ff   <= '0;
         vspeed_ff     <= '0;
         aspeed_ff     <= '0;
         near_ff       <= '0;
         tick_ff       <= '0;
         marks_ff      <= '0;
         start_alt_ff  <= '0;
         start_alts_ff <= '0;
         blink_cnt_ff  <= '0;
         blink_ff      <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_FLASH_TICKS: flash_dur_ff  <= csr_data;
               CSR_BLINK_HALF:  blink_half_ff <= csr_data;
               default: ;
            endcase
         end
         if (fire) begin
            flags_ff      <= flags_in;
            alt_now_ff    <= alt_now_in;
            alt_lock_ff   <= alt_lock_in;
            vspeed_ff     <= vspeed_in;
            aspeed_ff     <= aspeed_in;
            near_ff       <= near_in;
            tick_ff       <= tick_in;
            marks_ff      <= marks_in;
            start_alt_ff  <= start_alt_in;
            start_alts_ff <= start_alts_in;
            blink_cnt_ff  <= blink_cnt_in;
            blink_ff      <= blink_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_cmd_ff   <= req_tuser;
         in_id_ff    <= req_tdata[4:0];
         in_value_ff <= req_tdata[22:5];
      end
      if (fire) begin
         out_data_ff <= out_data_in;
      end
   end

`ifndef SYNTHESIS
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_blank_no_redraw: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[46] && rsp_tdata[47]))
      else $error("blank and redraw on the same beat");

   a_blink_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      (fire && !is_tick) |=> $stable(blink_ff) && $stable(marks_ff) && $stable(tick_ff))
      else $error("timer state moved on a message beat");

   a_setting_needs_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[45:28] != '0) |->
         (rsp_tdata[14:10] == MODE_ALT || rsp_tdata[14:10] == MODE_ALTS ||
          rsp_tdata[14:10] == MODE_IAS || rsp_tdata[14:10] == MODE_VS))
      else $error("setting value shown without a vertical mode that owns it");

   a_no_fire_into_full_output: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |=> $stable(out_data_ff))
      else $error("result register overwritten while stalled");
`endif

endmodule

// File: design/apma_mode_decode.sv
// ----------------------------------------------------------------------------
// apma_mode_decode
// Priority selection of the active and armed lateral and vertical modes
// from the mode flag word and the within-50ft proximity flag.
// ----------------------------------------------------------------------------
module apma_mode_decode
   import apma_pkg::*;
(
   input  mode_flags_type flags,
   input  logic           near_50,
   output mode_sel_type   modes
);

   logic vor, loc, gps, bc, hdg, rol, lvl, apr;
   logic alt, alts, ias, vs, pit, ga, gs_arm, gs_act;
   mode_code_type act_lat, arm_lat, act_vert, arm_vert_one, arm_vert_two;

   assign vor    = flags[FLAG_VOR];
   assign loc    = flags[FLAG_LOC];
   assign gps    = flags[FLAG_GPS];
   assign bc     = flags[FLAG_BC];
   assign hdg    = flags[FLAG_HDG];
   assign rol    = flags[FLAG_ROL];
   assign lvl    = flags[FLAG_LVL];
   assign apr    = flags[FLAG_APR];
   assign alt    = flags[FLAG_ALT];
   assign alts   = flags[FLAG_ALTS];
   assign ias    = flags[FLAG_IAS];
   assign vs     = flags[FLAG_VS];
   assign pit    = flags[FLAG_PIT];
   assign ga     = flags[FLAG_GA];
   assign gs_arm = flags[FLAG_GS_ARM];
   assign gs_act = flags[FLAG_GS_ACT];

   // active lateral
   always_comb begin
      if (lvl && vor && loc && !gps)       act_lat = MODE_LOC;
      else if (lvl && vor && !loc && !gps) act_lat = MODE_VOR;
      else if (lvl && vor && gps)          act_lat = MODE_GPS;
      else if (lvl && bc)                  act_lat = MODE_BC;
      else if (rol)                        act_lat = MODE_ROL;
      else if (bc && !hdg)                 act_lat = MODE_BC;
      else if (hdg)                        act_lat = MODE_HDG;
      else if (vor && loc && !gps)         act_lat = MODE_LOC;
      else if (apr && loc && !gps)         act_lat = MODE_LOC;
      else if (vor && gps)                 act_lat = MODE_GPS;
      else if (vor)                        act_lat = MODE_VOR;
      else                                 act_lat = MODE_NONE;
   end

   // armed lateral: roll takes precedence over heading
   always_comb begin
      if (rol && loc)                 arm_lat = MODE_LOC;
      else if (rol && bc)             arm_lat = MODE_BC;
      else if (rol && vor && !gps)    arm_lat = MODE_VOR;
      else if (rol && vor && gps)     arm_lat = MODE_GPS;
      else if (hdg && bc)             arm_lat = MODE_BC;
      else if (hdg && vor && !gps)    arm_lat = loc ? MODE_LOC : MODE_VOR;
      else if (hdg && vor && gps)     arm_lat = MODE_GPS;
      else                            arm_lat = MODE_NONE;
   end

   always_comb begin
      if (alt && !alts)                act_vert = MODE_ALT;
      else if (alt && alts && near_50) act_vert = MODE_ALT;
      else if (alts)                   act_vert = MODE_ALTS;
      else if (ias)                    act_vert = MODE_IAS;
      else if (vs)                     act_vert = MODE_VS;
      else if (lvl)                    act_vert = MODE_LVL;
      else if (pit)                    act_vert = MODE_PIT;
      else if (gps && gs_act)          act_vert = MODE_GP;
      else if (gs_act)                 act_vert = MODE_GS_ACT;
      else                             act_vert = MODE_NONE;
   end

   always_comb begin
      if (pit || ias)  arm_vert_one = MODE_ALTS;
      else if (vs)     arm_vert_one = MODE_VS;
      else if (ga)     arm_vert_one = MODE_ALTS;
      else if (alts)   arm_vert_one = MODE_ALT;
      else             arm_vert_one = MODE_NONE;
   end

   always_comb begin
      if (gps && gs_arm) arm_vert_two = MODE_GP;
      else if (gs_arm)   arm_vert_two = MODE_GS_ARM;
      else               arm_vert_two = MODE_NONE;
   end

   assign modes = '{active_lateral:     act_lat,
                    armed_lateral:      arm_lat,
                    active_vertical:    act_vert,
                    armed_vertical_one: arm_vert_one,
                    armed_vertical_two: arm_vert_two};

endmodule

// File: bench/autopilot_mode_annunciator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// autopilot_mode_annunciator_test
// Self-checking bench for the mode annunciator. Message and tick beats are
// driven on the request stream and mirrored into a predictor of the mode
// flags, values, flash timers and blink phase. Every result beat is compared
// field by field with the oldest prediction, under several register settings
// and with random gaps on both streams.
// ----------------------------------------------------------------------------
module autopilot_mode_annunciator_test;
   import apma_pkg::*;

   localparam int unsigned RESET_CYCLES    = 12;
   localparam int unsigned PHASES          = 7;
   localparam int unsigned ITEMS_PER_PHASE = 260;
   localparam int unsigned RESULT_LATENCY  = 2;
   localparam int unsigned CYCLE_LIMIT     = 400000;
   localparam int unsigned MAX_REPORTS     = 40;
   localparam int unsigned FLASH_ALT       = 0;
   localparam int unsigned FLASH_ALTS      = 1;

   // same layout as rsp_tdata, highest field first
   typedef struct packed {
      logic                redraw;
      logic                blank;
      logic signed [17:0]  setting;
      logic                blink_on;
      logic                alts_flashing;
      logic                alt_flashing;
      mode_code_type       armed_vertical_two;
      mode_code_type       armed_vertical_one;
      mode_code_type       active_vertical;
      mode_code_type       armed_lateral;
      mode_code_type       active_lateral;
   } annunciation_type;

   class annunciation_board;
      int unsigned      mismatches    = 0;
      int unsigned      beats_checked = 0;
      int unsigned      flash_beats   = 0;
      int unsigned      blank_beats   = 0;
      int unsigned      redraw_beats  = 0;
      annunciation_type expected_q[$];

      logic [15:0]      flash_ticks    = FLASH_TICKS_RESET;
      logic [15:0]      blink_half     = BLINK_HALF_RESET;

      mode_flags_type   flags          = '0;
      logic [17:0]      altitude_now   = '0;
      logic [17:0]      altitude_lock  = '0;
      logic [17:0]      vertical_speed = '0;
      logic [17:0]      airspeed_lock  = '0;
      logic             near_50        = 1'b0;
      logic             near_200       = 1'b0;
      logic [31:0]      tick_count     = '0;
      logic [1:0]       flash_on       = '0;
      logic [31:0]      flash_start [2] = '{32'd0, 32'd0};
      logic [15:0]      blink_count    = '0;
      logic             blink_visible  = 1'b1;

      function mode_code_type lateral_active();
         logic vor, loc, gps, bc, hdg;
         vor = flags[FLAG_VOR];
         loc = flags[FLAG_LOC];
         gps = flags[FLAG_GPS];
         bc  = flags[FLAG_BC];
         hdg = flags[FLAG_HDG];
         // level mode lets a captured nav source win over roll
         if (flags[FLAG_LVL]) begin
            if (vor && loc && !gps) return MODE_LOC;
            if (vor && !loc && !gps) return MODE_VOR;
            if (vor && gps) return MODE_GPS;
            if (bc) return MODE_BC;
         end
         if (flags[FLAG_ROL]) return MODE_ROL;
         if (bc && !hdg) return MODE_BC;
         if (hdg) return MODE_HDG;
         if (vor && loc && !gps) return MODE_LOC;
         if (flags[FLAG_APR] && loc && !gps) return MODE_LOC;
         if (vor && gps) return MODE_GPS;
         if (vor) return MODE_VOR;
         return MODE_NONE;
      endfunction

      function mode_code_type lateral_armed();
         logic vor, loc, gps, bc;
         vor = flags[FLAG_VOR];
         loc = flags[FLAG_LOC];
         gps = flags[FLAG_GPS];
         bc  = flags[FLAG_BC];
         if (flags[FLAG_ROL]) begin
            if (loc) return MODE_LOC;
            if (bc) return MODE_BC;
            if (vor && !gps) return MODE_VOR;
            if (vor && gps) return MODE_GPS;
         end
         if (flags[FLAG_HDG]) begin
            if (bc) return MODE_BC;
            if (vor && !gps) return loc ? MODE_LOC : MODE_VOR;
            if (vor && gps) return MODE_GPS;
         end
         return MODE_NONE;
      endfunction

      function mode_code_type vertical_active();
         if (flags[FLAG_ALT] && !flags[FLAG_ALTS]) return MODE_ALT;
         if (flags[FLAG_ALT] && flags[FLAG_ALTS] && near_50) return MODE_ALT;
         if (flags[FLAG_ALTS]) return MODE_ALTS;
         if (flags[FLAG_IAS]) return MODE_IAS;
         if (flags[FLAG_VS]) return MODE_VS;
         if (flags[FLAG_LVL]) return MODE_LVL;
         if (flags[FLAG_PIT]) return MODE_PIT;
         if (flags[FLAG_GPS] && flags[FLAG_GS_ACT]) return MODE_GP;
         if (flags[FLAG_GS_ACT]) return MODE_GS_ACT;
         return MODE_NONE;
      endfunction

      function mode_code_type vertical_armed_one();
         if (flags[FLAG_PIT]) return MODE_ALTS;
         if (flags[FLAG_IAS]) return MODE_ALTS;
         if (flags[FLAG_VS]) return MODE_VS;
         if (flags[FLAG_GA]) return MODE_ALTS;
         if (flags[FLAG_ALTS]) return MODE_ALT;
         return MODE_NONE;
      endfunction

      function mode_code_type vertical_armed_two();
         if (flags[FLAG_GPS] && flags[FLAG_GS_ARM]) return MODE_GP;
         if (flags[FLAG_GS_ARM]) return MODE_GS_ARM;
         return MODE_NONE;
      endfunction

      // returns 1 when the flash starts, restarts or ends on this tick
      function logic run_flash(int unsigned idx, logic cond);
         logic expired;
         expired = (tick_count - flash_start[idx]) > {16'd0, flash_ticks};
         if (cond) begin
            if (!flash_on[idx] || expired) begin
               flash_on[idx]    = 1'b1;
               flash_start[idx] = tick_count;
               return 1'b1;
            end
         end else if (flash_on[idx] && expired) begin
            flash_on[idx] = 1'b0;
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function void note_request(logic cmd, msg_id_type id, logic [17:0] value);
         annunciation_type want;
         logic             blank, redraw, alts_capture, alt_capture;
         blank  = 1'b0;
         redraw = 1'b0;
         if (cmd == CMD_MESSAGE) begin
            if (id <= MSG_FLAG_LAST) begin
               flags[id] = (value != '0);
               redraw    = 1'b1;
            end else begin
               case (id)
                  MSG_ALT_NOW: begin
                     altitude_now = value;
                     redraw       = 1'b1;
                  end
                  MSG_NEAR_50: begin
                     near_50 = (value != '0);
                     redraw  = 1'b1;
                  end
                  MSG_NEAR_200: begin
                     near_200 = (value != '0);
                     redraw   = 1'b1;
                  end
                  MSG_ALT_LOCK: begin
                     altitude_lock = value;
                     redraw        = 1'b1;
                  end
                  MSG_VERT_SPEED: begin
                     vertical_speed = value;
                     redraw         = 1'b1;
                  end
                  MSG_AIRSPEED: begin
                     airspeed_lock = value;
                     redraw        = 1'b1;
                  end
                  MSG_SHUTDOWN: blank = 1'b1;
                  MSG_POWER_SAVE: blank = (value == 18'd1);
                  default: ;
               endcase
            end
         end else begin
            tick_count   = tick_count + 32'd1;
            alts_capture = near_200 && flags[FLAG_ALTS] &&
                           (flags[FLAG_PIT] || flags[FLAG_IAS] ||
                            flags[FLAG_VS] || flags[FLAG_GA]);
            alt_capture  = flags[FLAG_ALT] && !flags[FLAG_ALTS] && near_50;
            // ALTS timer runs first, both see the advanced tick count
            if (run_flash(FLASH_ALTS, alts_capture)) redraw = 1'b1;
            if (run_flash(FLASH_ALT, alt_capture)) redraw = 1'b1;
            blink_count = blink_count + 16'd1;
            if (blink_count >= blink_half) begin
               blink_count   = '0;
               blink_visible = ~blink_visible;
               if (flash_on != 2'b00) redraw = 1'b1;
            end
         end

         want.active_lateral     = lateral_active();
         want.armed_lateral      = lateral_armed();
         want.active_vertical    = vertical_active();
         want.armed_vertical_one = vertical_armed_one();
         want.armed_vertical_two = vertical_armed_two();
         want.alt_flashing       = flash_on[FLASH_ALT];
         want.alts_flashing      = flash_on[FLASH_ALTS];
         want.blink_on           = blink_visible;
         case (want.active_vertical)
            MODE_ALT:  want.setting = altitude_now;
            MODE_ALTS: want.setting = altitude_lock;
            MODE_IAS:  want.setting = airspeed_lock;
            MODE_VS:   want.setting = vertical_speed;
            default:   want.setting = '0;
         endcase
         want.blank  = blank;
         want.redraw = redraw;
         expected_q.push_back(want);
      endfunction

      task report(string what);
         if (mismatches < MAX_REPORTS) $display("mismatch: %s", what);
         mismatches++;
      endtask

      task compare_field(string name, int got, int want);
         if (got != want)
            report($sformatf("beat %0d %s is %0d, expected %0d",
                             beats_checked, name, got, want));
      endtask

      task check_result(annunciation_type got);
         annunciation_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("result beat %h with no request waiting", got));
            return;
         end
         want = expected_q.pop_front();
         beats_checked++;
         if (want.alt_flashing || want.alts_flashing) flash_beats++;
         if (want.blank) blank_beats++;
         if (want.redraw) redraw_beats++;
         compare_field("active_lateral", int'(got.active_lateral),
                       int'(want.active_lateral));
         compare_field("armed_lateral", int'(got.armed_lateral),
                       int'(want.armed_lateral));
         compare_field("active_vertical", int'(got.active_vertical),
                       int'(want.active_vertical));
         compare_field("armed_vertical_one", int'(got.armed_vertical_one),
                       int'(want.armed_vertical_one));
         compare_field("armed_vertical_two", int'(got.armed_vertical_two),
                       int'(want.armed_vertical_two));
         compare_field("alt_flashing", int'(got.alt_flashing), int'(want.alt_flashing));
         compare_field("alts_flashing", int'(got.alts_flashing), int'(want.alts_flashing));
         compare_field("blink_on", int'(got.blink_on), int'(want.blink_on));
         compare_field("setting_value", int'(got.setting), int'(want.setting));
         compare_field("blank", int'(got.blank), int'(want.blank));
         compare_field("redraw", int'(got.redraw), int'(want.redraw));
      endtask
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;
   logic        req_tuser  = CMD_MESSAGE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_index  = CSR_FLASH_TICKS;
   logic [15:0] csr_data   = '0;

   int unsigned idle_pct    = 0;
   int unsigned stall_pct   = 0;
   int unsigned cycle_count = 0;

   // per phase: flash duration, blink half period, sender idle, receiver stall
   int unsigned phase_duration [PHASES] = '{3000, 0, 65535, 7, 40, 2, 25};
   int unsigned phase_half     [PHASES] = '{500, 0, 65535, 1, 3, 11, 2};
   int unsigned phase_idle     [PHASES] = '{0, 78, 0, 16, 0, 78, 0};
   int unsigned phase_stall    [PHASES] = '{0, 0, 78, 16, 0, 0, 78};

   annunciation_board board = new;

   autopilot_mode_annunciator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timed out after %0d cycles", cycle_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   // result side: check each accepted beat, then pick the next ready
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
      rsp_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
   end

   task automatic send_item(logic cmd, msg_id_type id, logic [17:0] value);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {1'b0, value, id};
      do @(posedge clock); while (!req_tready);
      board.note_request(cmd, id, value);
   endtask

   task automatic send_random_item();
      int unsigned pick;
      msg_id_type  id;
      logic [17:0] value;
      pick  = $urandom_range(99);
      value = 18'($urandom_range(18'h3FFFF));
      id    = msg_id_type'($urandom_range(31));
      if (pick < 40) begin
         send_item(CMD_TICK, id, value);
      end else if (pick < 75) begin
         // mostly plain set and clear, sometimes a wide nonzero value
         pick = $urandom_range(9);
         if (pick < 5) value = '0;
         else if (pick < 9) value = 18'd1;
         send_item(CMD_MESSAGE, msg_id_type'($urandom_range(MSG_FLAG_LAST)), value);
      end else if (pick < 90) begin
         id = msg_id_type'($urandom_range(MSG_AIRSPEED, MSG_ALT_NOW));
         if ((id == MSG_NEAR_50 || id == MSG_NEAR_200) && $urandom_range(3) != 0)
            value = 18'($urandom_range(1));
         send_item(CMD_MESSAGE, id, value);
      end else begin
         id = msg_id_type'($urandom_range(31, MSG_SHUTDOWN));
         if ($urandom_range(2) == 0) value = 18'd1;
         send_item(CMD_MESSAGE, id, value);
      end
   endtask

   task automatic write_settings(logic [15:0] duration, logic [15:0] half_period);
      csr_valid <= 1'b1;
      csr_index <= CSR_FLASH_TICKS;
      csr_data  <= duration;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_BLINK_HALF;
      csr_data  <= half_period;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.flash_ticks = duration;
      board.blink_half  = half_period;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (2 * RESULT_LATENCY) @(posedge clock);
   endtask

   initial begin
      int unsigned phase;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // altitude capture: ALT armed inside 50 ft starts the ALT flash
      send_item(CMD_MESSAGE, msg_id_type'(FLAG_ALT), 18'd1);
      send_item(CMD_MESSAGE, MSG_NEAR_50, 18'h20000);
      send_item(CMD_TICK, 5'd31, 18'h3FFFF);
      send_item(CMD_MESSAGE, MSG_ALT_NOW, 18'h1FFFF);
      send_item(CMD_MESSAGE, MSG_ALT_LOCK, 18'h20000);
      send_item(CMD_MESSAGE, msg_id_type'(FLAG_ALTS), 18'h3FFFF);
      send_item(CMD_MESSAGE, MSG_VERT_SPEED, 18'h3FFFF);
      send_item(CMD_MESSAGE, MSG_AIRSPEED, 18'd1);
      send_item(CMD_MESSAGE, msg_id_type'(FLAG_IAS), 18'd1);
      // within 200 ft with ALTS and a climb mode starts the ALTS flash
      send_item(CMD_MESSAGE, MSG_NEAR_200, 18'd1);
      send_item(CMD_TICK, 5'd0, 18'd0);
      send_item(CMD_MESSAGE, MSG_NEAR_50, 18'd0);
      // blanking, and power save with a value other than enter
      send_item(CMD_MESSAGE, MSG_SHUTDOWN, 18'd0);
      send_item(CMD_MESSAGE, MSG_POWER_SAVE, 18'd1);
      send_item(CMD_MESSAGE, MSG_POWER_SAVE, 18'h3FFFF);
      // unused ids change nothing
      send_item(CMD_MESSAGE, 5'd26, 18'd1);
      send_item(CMD_MESSAGE, 5'd31, 18'h3FFFF);
      // glidepath shows up once GPS joins the glideslope flags
      send_item(CMD_MESSAGE, msg_id_type'(FLAG_GS_ACT), 18'd1);
      send_item(CMD_MESSAGE, msg_id_type'(FLAG_GS_ARM), 18'd1);
      send_item(CMD_MESSAGE, msg_id_type'(FLAG_GPS), 18'd1);
      send_item(CMD_MESSAGE, msg_id_type'(FLAG_LVL), 18'd1);
      send_item(CMD_MESSAGE, msg_id_type'(FLAG_VOR), 18'd1);
      send_item(CMD_MESSAGE, msg_id_type'(FLAG_LOC), 18'd1);
      send_item(CMD_TICK, 5'd0, 18'd0);
      send_item(CMD_MESSAGE, msg_id_type'(FLAG_ROL), 18'd0);

      for (phase = 0; phase < PHASES; phase++) begin
         if (phase != 0) begin
            drain();
            write_settings(16'(phase_duration[phase]), 16'(phase_half[phase]));
         end
         idle_pct  = phase_idle[phase];
         stall_pct = phase_stall[phase];
         repeat (ITEMS_PER_PHASE) send_random_item();
      end
      drain();

      $display("checked %0d result beats under %0d register settings",
               board.beats_checked, PHASES);
      $display("%0d beats under a capture flash, %0d blanking, %0d redraw",
               board.flash_beats, board.blank_beats, board.redraw_beats);
      if (board.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", board.mismatches);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
